/* rtl/core/selection_sort_engine_assert.svh */
// ----------------------------------------------------------------------------
// selection_sort_engine_assert.svh
// Assertion macros shared by the selection sort engine RTL.
// ----------------------------------------------------------------------------
`ifndef SELECTION_SORT_ENGINE_ASSERT_SVH
`define SELECTION_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, idle during reset.
`define SSORT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, idle during reset.
`define SSORT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ssort_pkg.sv */
// ----------------------------------------------------------------------------
// ssort_pkg
// Sizes and widths shared by the selection sort engine.
// ----------------------------------------------------------------------------
package ssort_pkg;

    // Number of entries in the value store (2 to 64).
    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    // Store address width and a count width that can also hold DEPTH itself.
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

endpackage

/* rtl/core/selection_sort_engine.sv */
// ----------------------------------------------------------------------------
// selection_sort_engine
// Collects signed words into a store, sorts them ascending and streams them.
// ----------------------------------------------------------------------------
// Each accepted word (start high while busy is low) is appended to the store,
// and busy stays low while loading. A word with last_in set closes the set;
// words arriving with the store full are dropped and flagged through overflow.
// The set is then sorted by selection sort on a single signed comparator that
// reads one store entry per cycle, and then emitted. Sorted words leave one per
// cycle, each on the result ports for exactly one cycle with result_valid high;
// the receiver cannot stall them. busy is high from the closing word until the
// final word (last_out high) is presented.
module selection_sort_engine
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [ssort_pkg::DATA_W-1:0] value,
    input  logic                                last_in,
    output logic                                busy,
    output logic                                result_valid,
    output logic signed [ssort_pkg::DATA_W-1:0] sorted_value,
    output logic                                last_out,
    output logic                                overflow
);

    `include "selection_sort_engine_assert.svh"

    typedef enum logic [5:0]
    {
        S_IDLE    = 6'b000001,
        S_PASS    = 6'b000010,
        S_SCAN    = 6'b000100,
        S_SWAP_LO = 6'b001000,
        S_SWAP_HI = 6'b010000,
        S_EMIT    = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;
    logic [ssort_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                           dropped_reg, dropped_next;
    logic [ssort_pkg::IDX_W-1:0]    i_reg, i_next;
    logic [ssort_pkg::CNT_W-1:0]    j_reg, j_next;
    logic [ssort_pkg::IDX_W-1:0]    pick_reg, pick_next;
    logic [ssort_pkg::DATA_W-1:0]   min_reg, min_next;
    logic [ssort_pkg::DATA_W-1:0]   cur_reg, cur_next;
    logic [ssort_pkg::IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                           pend_vld_reg, pend_vld_next;
    logic                           first_reg, first_next;
    logic                           result_valid_reg, result_valid_next;
    logic [ssort_pkg::DATA_W-1:0]   sorted_value_reg, sorted_value_next;
    logic                           last_out_reg, last_out_next;
    logic                           overflow_reg, overflow_next;

    logic [ssort_pkg::DATA_W-1:0]   store_mem [ssort_pkg::DEPTH];
    logic [ssort_pkg::DATA_W-1:0]   rd_data_reg;
    logic [ssort_pkg::IDX_W-1:0]    rd_addr;
    logic                           wr_en;
    logic [ssort_pkg::IDX_W-1:0]    wr_addr;
    logic [ssort_pkg::DATA_W-1:0]   wr_data;

    logic                           room;
    logic [ssort_pkg::CNT_W-1:0]    load_count;
    logic                           issue;

    // Value store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign room       = (count_reg < ssort_pkg::CNT_W'(ssort_pkg::DEPTH));
    assign load_count = room ? (count_reg + ssort_pkg::CNT_W'(1)) : count_reg;
    assign issue      = (j_reg < count_reg);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        dropped_next      = dropped_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        pick_next         = pick_reg;
        min_next          = min_reg;
        cur_next          = cur_reg;
        pend_idx_next     = pend_idx_reg;
        pend_vld_next     = pend_vld_reg;
        first_next        = first_reg;
        result_valid_next = 1'b0;
        sorted_value_next = rd_data_reg;
        last_out_next     = 1'b0;
        overflow_next     = dropped_reg;
        wr_en             = 1'b0;
        wr_addr           = count_reg[ssort_pkg::IDX_W-1:0];
        wr_data           = value;
        rd_addr           = j_reg[ssort_pkg::IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    count_next = load_count;
                    if (room)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last_in)
                    begin
                        if (load_count >= ssort_pkg::CNT_W'(2))
                        begin
                            i_next     = '0;
                            state_next = S_PASS;
                        end
                        else
                        begin
                            j_next        = '0;
                            pend_vld_next = 1'b0;
                            state_next    = S_EMIT;
                        end
                    end
                end
            end

            S_PASS:
            begin
                // Fetch the head of the unsorted part as the first candidate.
                rd_addr       = i_reg;
                first_next    = 1'b1;
                pend_vld_next = 1'b0;
                j_next        = ssort_pkg::CNT_W'(i_reg) + ssort_pkg::CNT_W'(1);
                state_next    = S_SCAN;
            end

            S_SCAN:
            begin
                if (first_reg)
                begin
                    min_next   = rd_data_reg;
                    cur_next   = rd_data_reg;
                    pick_next  = i_reg;
                    first_next = 1'b0;
                end
                else if (pend_vld_reg && ($signed(rd_data_reg) < $signed(min_reg)))
                begin
                    // Strictly smaller only, so the first minimum is kept.
                    min_next  = rd_data_reg;
                    pick_next = pend_idx_reg;
                end
                if (issue)
                begin
                    pend_vld_next = 1'b1;
                    pend_idx_next = j_reg[ssort_pkg::IDX_W-1:0];
                    j_next        = j_reg + ssort_pkg::CNT_W'(1);
                end
                else
                begin
                    pend_vld_next = 1'b0;
                end
                if (!first_reg && !pend_vld_reg && !issue)
                begin
                    state_next = S_SWAP_LO;
                end
            end

            S_SWAP_LO:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_reg;
                wr_data    = min_reg;
                state_next = S_SWAP_HI;
            end

            S_SWAP_HI:
            begin
                wr_en   = 1'b1;
                wr_addr = pick_reg;
                wr_data = cur_reg;
                if ((ssort_pkg::CNT_W'(i_reg) + ssort_pkg::CNT_W'(2)) < count_reg)
                begin
                    i_next     = i_reg + ssort_pkg::IDX_W'(1);
                    state_next = S_PASS;
                end
                else
                begin
                    j_next        = '0;
                    pend_vld_next = 1'b0;
                    state_next    = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (pend_vld_reg)
                begin
                    result_valid_next = 1'b1;
                    last_out_next     = (ssort_pkg::CNT_W'(pend_idx_reg) ==
                                         (count_reg - ssort_pkg::CNT_W'(1)));
                end
                if (issue)
                begin
                    pend_vld_next = 1'b1;
                    pend_idx_next = j_reg[ssort_pkg::IDX_W-1:0];
                    j_next        = j_reg + ssort_pkg::CNT_W'(1);
                end
                else
                begin
                    pend_vld_next = 1'b0;
                end
                if (!pend_vld_reg && !issue)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            dropped_reg      <= 1'b0;
            pend_vld_reg     <= 1'b0;
            first_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            dropped_reg      <= dropped_next;
            pend_vld_reg     <= pend_vld_next;
            first_reg        <= first_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg            <= i_next;
        j_reg            <= j_next;
        pick_reg         <= pick_next;
        min_reg          <= min_next;
        cur_reg          <= cur_next;
        pend_idx_reg     <= pend_idx_next;
        sorted_value_reg <= sorted_value_next;
        last_out_reg     <= last_out_next;
        overflow_reg     <= overflow_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign sorted_value = $signed(sorted_value_reg);
    assign last_out     = last_out_reg;
    assign overflow     = overflow_reg;

    `SSORT_ASSERT_NOW(a_count_range, 1'b1,
        count_reg <= ssort_pkg::CNT_W'(ssort_pkg::DEPTH), "word count exceeds store depth")

    `SSORT_ASSERT_NEXT(a_close_sets_busy, start && !busy && last_in,
        busy, "closing word did not start the sort")

    `SSORT_ASSERT_NEXT(a_single_last, result_valid && last_out,
        !result_valid, "word presented after the final word of a set")

    `SSORT_ASSERT_NOW(a_pick_in_range, (state_reg == S_SCAN) && !first_reg,
        (ssort_pkg::CNT_W'(pick_reg) < count_reg) && (pick_reg >= i_reg),
        "selected minimum lies outside the unsorted part")

endmodule
